[sv/upi_pkg.sv]
// Package with the constants, types and arctangent table of the pose integrator.
`timescale 1ns / 1ps
`default_nettype none

package upi_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int ANGLE_WIDTH    = 16;
    localparam int CORDIC_STEPS   = 16;

    localparam int TIME_WIDTH     = 16;
    localparam int VEL_WIDTH      = 16;
    localparam int SCALED_WIDTH   = 32;
    localparam int CORDIC_WIDTH   = 34;
    localparam int PROD_WIDTH     = 2 * CORDIC_WIDTH;
    localparam int DELTA_WIDTH    = 24;
    localparam int SUM_WIDTH      = ((POSITION_WIDTH > DELTA_WIDTH) ?
                                     POSITION_WIDTH : DELTA_WIDTH) + 1;
    localparam int POS_SHIFT      = 42;
    localparam int TURN_SHIFT     = 60 - ANGLE_WIDTH;
    localparam int ITER_WIDTH     = $clog2(CORDIC_STEPS);

    localparam logic [TIME_WIDTH-1:0] TIME_STEP_RESET = 16'd6554;
    localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_H,
        ST_ADD_H,
        ST_FINISH
    } upi_state_t;

    typedef enum logic [1:0] {
        MUL_COS,
        MUL_SIN,
        MUL_TURN
    } upi_mul_sel_t;

    typedef struct packed {
        logic                  load;
        logic                  rotate;
        logic [ITER_WIDTH-1:0] iter;
        logic                  mul_en;
        upi_mul_sel_t          mul_sel;
        logic                  upd_x;
        logic                  upd_y;
        logic                  upd_h;
        logic                  out_load;
    } upi_cmd_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/upi_ctrl.sv]
// Controller state machine that sequences the rotation, multiply and update steps.
`timescale 1ns / 1ps
`default_nettype none

module upi_ctrl
    import upi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output upi_cmd_t      cmd
);

    upi_state_t            state_reg, state_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;
    logic                  last_iter;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_iter = (iter_reg == ITER_WIDTH'(CORDIC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                iter_next = '0;
                if (accept)
                begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                iter_next = iter_reg + 1'b1;
                if (last_iter)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_MUL_H;
            ST_MUL_H:  state_next = ST_ADD_H;
            ST_ADD_H:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_COS;
        cmd.iter       = iter_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:   cmd.load = accept;
            ST_ROTATE: cmd.rotate = 1'b1;
            ST_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_COS;
            end
            ST_MUL_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SIN;
                cmd.upd_x   = 1'b1;
            end
            ST_MUL_H:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TURN;
                cmd.upd_y   = 1'b1;
            end
            ST_ADD_H:  cmd.upd_h = 1'b1;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd = '0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/upi_datapath.sv]
// Datapath with the pose registers, the CORDIC unit, the shared multiplier and the outputs.
`timescale 1ns / 1ps
`default_nettype none

module upi_datapath
    import upi_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire upi_cmd_t                    cmd,
    input  wire logic                        cfg_write,
    input  wire logic [TIME_WIDTH-1:0]       cfg_data,
    input  wire logic signed [VEL_WIDTH-1:0] linear_velocity,
    input  wire logic signed [VEL_WIDTH-1:0] angular_velocity,
    output logic signed [POSITION_WIDTH-1:0] x_position,
    output logic signed [POSITION_WIDTH-1:0] y_position,
    output logic [ANGLE_WIDTH-1:0]           heading,
    output logic                             position_saturated
);

    localparam logic signed [PROD_WIDTH-1:0] POS_HALF  = PROD_WIDTH'(1) << (POS_SHIFT - 1);
    localparam logic signed [PROD_WIDTH-1:0] TURN_HALF = PROD_WIDTH'(1) << (TURN_SHIFT - 1);
    localparam logic signed [SUM_WIDTH-1:0]  POS_MAX   =
        SUM_WIDTH'((64'd1 << (POSITION_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_WIDTH-1:0]  POS_MIN   = -POS_MAX - SUM_WIDTH'(1);

    logic [TIME_WIDTH-1:0]             time_step_reg;
    logic signed [POSITION_WIDTH-1:0]  pose_x_reg, pose_x_next;
    logic signed [POSITION_WIDTH-1:0]  pose_y_reg, pose_y_next;
    logic [ANGLE_WIDTH-1:0]            pose_heading_reg, pose_heading_next;
    logic signed [SCALED_WIDTH-1:0]    tv_reg, tw_reg;
    logic signed [CORDIC_WIDTH-1:0]    cx_reg, cy_reg, cz_reg;
    logic                              flip_reg;
    logic signed [PROD_WIDTH-1:0]      prod_reg;
    logic                              sat_reg;

    logic signed [SCALED_WIDTH:0]      tv_full, tw_full;
    logic [31:0]                       z32;
    logic                              flip;
    logic signed [31:0]                z_init;
    logic signed [CORDIC_WIDTH-1:0]    x_sh, y_sh, atan_val;
    logic signed [CORDIC_WIDTH-1:0]    cos_val, sin_val;
    logic signed [CORDIC_WIDTH-1:0]    mul_a, mul_b;
    logic signed [PROD_WIDTH-1:0]      pos_round, pos_shifted;
    logic signed [PROD_WIDTH-1:0]      turn_round, turn_shifted;
    logic signed [DELTA_WIDTH-1:0]     pos_delta;
    logic signed [SUM_WIDTH-1:0]       pos_sum;
    logic signed [POSITION_WIDTH-1:0]  pos_base, pos_clamped;
    logic                              pos_clip;

    assign tv_full = $signed({1'b0, time_step_reg}) * linear_velocity;
    assign tw_full = $signed({1'b0, time_step_reg}) * angular_velocity;

    assign z32    = {pose_heading_reg, {(32 - ANGLE_WIDTH){1'b0}}};
    assign flip   = z32[31] ^ z32[30];
    assign z_init = $signed({z32[31] ^ flip, z32[30:0]});

    assign x_sh     = cx_reg >>> cmd.iter;
    assign y_sh     = cy_reg >>> cmd.iter;
    assign atan_val = $signed({{(CORDIC_WIDTH - 32){1'b0}}, atan_entry(5'(cmd.iter))});

    assign cos_val = flip_reg ? -cx_reg : cx_reg;
    assign sin_val = flip_reg ? -cy_reg : cy_reg;

    always_comb
    begin
        mul_a = CORDIC_WIDTH'(tv_reg);
        mul_b = cos_val;
        case (cmd.mul_sel)
            MUL_COS:  mul_b = cos_val;
            MUL_SIN:  mul_b = sin_val;
            MUL_TURN:
            begin
                mul_a = CORDIC_WIDTH'(tw_reg);
                mul_b = $signed({{(CORDIC_WIDTH - 32){1'b0}}, INV_TWO_PI_Q32});
            end
            default:  mul_b = cos_val;
        endcase
    end

    assign pos_round    = prod_reg + POS_HALF;
    assign pos_shifted  = pos_round >>> POS_SHIFT;
    assign pos_delta    = pos_shifted[DELTA_WIDTH-1:0];
    assign pos_base     = cmd.upd_y ? pose_y_reg : pose_x_reg;
    assign pos_sum      = SUM_WIDTH'(pos_base) + SUM_WIDTH'(pos_delta);

    always_comb
    begin
        pos_clip    = 1'b0;
        pos_clamped = pos_sum[POSITION_WIDTH-1:0];
        if (pos_sum > POS_MAX)
        begin
            pos_clip    = 1'b1;
            pos_clamped = POS_MAX[POSITION_WIDTH-1:0];
        end
        else if (pos_sum < POS_MIN)
        begin
            pos_clip    = 1'b1;
            pos_clamped = POS_MIN[POSITION_WIDTH-1:0];
        end
    end

    assign turn_round   = prod_reg + TURN_HALF;
    assign turn_shifted = turn_round >>> TURN_SHIFT;

    always_comb
    begin
        pose_x_next       = cmd.upd_x ? pos_clamped : pose_x_reg;
        pose_y_next       = cmd.upd_y ? pos_clamped : pose_y_reg;
        pose_heading_next = pose_heading_reg;
        if (cmd.upd_h)
        begin
            pose_heading_next = pose_heading_reg + turn_shifted[ANGLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= TIME_STEP_RESET;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                time_step_reg <= cfg_data;
            end
            pose_x_reg       <= pose_x_next;
            pose_y_reg       <= pose_y_next;
            pose_heading_reg <= pose_heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tv_reg   <= tv_full[SCALED_WIDTH-1:0];
            tw_reg   <= tw_full[SCALED_WIDTH-1:0];
            cx_reg   <= $signed({{(CORDIC_WIDTH - 32){1'b0}}, CORDIC_GAIN_Q30});
            cy_reg   <= '0;
            cz_reg   <= CORDIC_WIDTH'(z_init);
            flip_reg <= flip;
            sat_reg  <= 1'b0;
        end
        else if (cmd.rotate)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - y_sh;
                cy_reg <= cy_reg + x_sh;
                cz_reg <= cz_reg - atan_val;
            end
            else
            begin
                cx_reg <= cx_reg + y_sh;
                cy_reg <= cy_reg - x_sh;
                cz_reg <= cz_reg + atan_val;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if ((cmd.upd_x || cmd.upd_y) && pos_clip)
        begin
            sat_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            x_position         <= pose_x_reg;
            y_position         <= pose_y_reg;
            heading            <= pose_heading_reg;
            position_saturated <= sat_reg;
        end
    end

endmodule

`default_nettype wire

[sv/unicycle_pose_integrator.sv]
// Top level of the unicycle pose integrator: controller, datapath and assertions.
// Each accepted request runs 16 CORDIC rotation steps, three passes through the shared
// multiplier, one heading update and one output load before its result is valid.
// in_stall holds off a new request until the last one is loaded; the next one is taken while a result waits.
// Reset: rst_n clears the pose to zero and sets time_step to 6554 (about 0.1 s).
`timescale 1ns / 1ps
`default_nettype none

module unicycle_pose_integrator
    import upi_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [TIME_WIDTH-1:0]       cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [VEL_WIDTH-1:0] linear_velocity,
    input  wire logic signed [VEL_WIDTH-1:0] angular_velocity,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [POSITION_WIDTH-1:0] x_position,
    output logic signed [POSITION_WIDTH-1:0] y_position,
    output logic [ANGLE_WIDTH-1:0]           heading,
    output logic                             position_saturated
);

    upi_cmd_t cmd;

    assign cfg_ready = 1'b1;

    upi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    upi_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_data           (cfg_data),
        .linear_velocity    (linear_velocity),
        .angular_velocity   (angular_velocity),
        .x_position         (x_position),
        .y_position         (y_position),
        .heading            (heading),
        .position_saturated (position_saturated)
    );

    localparam logic signed [POSITION_WIDTH-1:0] OUT_MAX =
        {1'b0, {(POSITION_WIDTH - 1){1'b1}}};
    localparam logic signed [POSITION_WIDTH-1:0] OUT_MIN =
        {1'b1, {(POSITION_WIDTH - 1){1'b0}}};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input side not busy after an accepted request");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !cmd.out_load)
        else $error("result loaded right after a request was accepted");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_saturated) |->
        (x_position == OUT_MAX || x_position == OUT_MIN ||
         y_position == OUT_MAX || y_position == OUT_MIN))
        else $error("saturation flag set without a position at its limit");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rotate, cmd.upd_h, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

[verif/tb_unicycle_pose_integrator.sv]
// Self-checking testbench for the unicycle pose integrator with a built-in pose predictor.
`timescale 1ns / 1ps

module tb_unicycle_pose_integrator;
    import upi_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int CLAMP_TARGET = 8;
    localparam int DRIVE_CAP = 150;
    localparam int POS_FRACTION = 42;
    localparam int TURN_FRACTION = 60 - ANGLE_WIDTH;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam longint TURNS_PER_RADIAN = 64'd683565276;
    localparam longint UNIT_GAIN = 64'd652032874;
    localparam longint ARC_TURNS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam logic signed [VEL_WIDTH-1:0] DIR_V [18] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000,
        16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF
    };
    localparam logic signed [VEL_WIDTH-1:0] DIR_W [18] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7FFF,
        16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000
    };

    typedef struct {
        logic signed [POSITION_WIDTH-1:0] x;
        logic signed [POSITION_WIDTH-1:0] y;
        logic [ANGLE_WIDTH-1:0]           heading;
        logic                             saturated;
    } pose_t;

    class pose_ledger;
        logic [TIME_WIDTH-1:0]  step = TIME_STEP_RESET;
        longint                 pos_x = 0;
        longint                 pos_y = 0;
        logic [ANGLE_WIDTH-1:0] head = '0;
        pose_t                  pending_poses[$];
        int errors = 0;
        int requests = 0;
        int results = 0;
        int clamps_hi = 0;
        int clamps_lo = 0;
        int settings = 1;

        function void set_step(input logic [TIME_WIDTH-1:0] t);
            step = t;
            settings++;
        endfunction

        function int pending();
            return pending_poses.size();
        endfunction

        function longint round_off(input longint val, input int sh);
            return (val + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function void rotate_unit(output longint cos_q, output longint sin_q);
            logic [31:0] z32;
            logic        flip;
            longint      xr;
            longint      yr;
            longint      zr;
            longint      xn;
            int          i;
            z32 = 32'(head) << (32 - ANGLE_WIDTH);
            flip = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
            if (flip)
            begin
                z32 = z32 + 32'h8000_0000;
            end
            zr = longint'($signed(z32));
            xr = UNIT_GAIN;
            yr = 0;
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                if (zr >= 0)
                begin
                    xn = xr - (yr >>> i);
                    yr = yr + (xr >>> i);
                    zr = zr - ARC_TURNS[i];
                end
                else
                begin
                    xn = xr + (yr >>> i);
                    yr = yr - (xr >>> i);
                    zr = zr + ARC_TURNS[i];
                end
                xr = xn;
            end
            cos_q = flip ? -xr : xr;
            sin_q = flip ? -yr : yr;
        endfunction

        function longint clamp_axis(input longint val, inout logic sat);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (POSITION_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (val > hi)
            begin
                sat = 1'b1;
                clamps_hi++;
                return hi;
            end
            if (val < lo)
            begin
                sat = 1'b1;
                clamps_lo++;
                return lo;
            end
            return val;
        endfunction

        function void take_command(input logic signed [VEL_WIDTH-1:0] v,
                                   input logic signed [VEL_WIDTH-1:0] w);
            longint tv;
            longint tw;
            longint cos_q;
            longint sin_q;
            logic   sat;
            pose_t  want;
            tv = longint'(step) * longint'(v);
            tw = longint'(step) * longint'(w);
            rotate_unit(cos_q, sin_q);
            sat = 1'b0;
            pos_x = clamp_axis(pos_x + round_off(tv * cos_q, POS_FRACTION), sat);
            pos_y = clamp_axis(pos_y + round_off(tv * sin_q, POS_FRACTION), sat);
            head = head + ANGLE_WIDTH'(round_off(tw * TURNS_PER_RADIAN, TURN_FRACTION));
            want.x = POSITION_WIDTH'(pos_x);
            want.y = POSITION_WIDTH'(pos_y);
            want.heading = head;
            want.saturated = sat;
            pending_poses = {pending_poses, want};
            requests++;
        endfunction

        // Turn rate that brings the heading close to the target in one request.
        function logic signed [VEL_WIDTH-1:0] steer_rate(input logic [ANGLE_WIDTH-1:0] target);
            logic signed [ANGLE_WIDTH-1:0] diff;
            longint                        rate;
            diff = target - head;
            if (step == 0)
            begin
                return '0;
            end
            rate = (longint'(diff) <<< TURN_FRACTION) / (longint'(step) * TURNS_PER_RADIAN);
            return VEL_WIDTH'(rate);
        endfunction

        function void report(input string text);
            errors++;
            $display("%0t: %s", $time, text);
        endfunction

        function void compare(input string name, input longint want, input longint got);
            if (want != got)
            begin
                report($sformatf("%s mismatch, expected %0d, actual %0d", name, want, got));
            end
        endfunction

        function void match_pose(input logic signed [POSITION_WIDTH-1:0] x,
                                 input logic signed [POSITION_WIDTH-1:0] y,
                                 input logic [ANGLE_WIDTH-1:0] h,
                                 input logic sat);
            pose_t want;
            if (pending_poses.size() == 0)
            begin
                report($sformatf("result with no request outstanding, expected none, actual x=%0d",
                                 x));
                return;
            end
            want = pending_poses.pop_front();
            results++;
            compare("x_position", want.x, x);
            compare("y_position", want.y, y);
            compare("heading", want.heading, h);
            compare("position_saturated", want.saturated, sat);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TIME_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VEL_WIDTH-1:0] linear_velocity = '0;
    logic signed [VEL_WIDTH-1:0] angular_velocity = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [POSITION_WIDTH-1:0] x_position;
    logic signed [POSITION_WIDTH-1:0] y_position;
    logic [ANGLE_WIDTH-1:0] heading;
    logic position_saturated;

    pose_ledger board;
    int gap_odds = 0;
    int stall_odds = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    unicycle_pose_integrator dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .linear_velocity    (linear_velocity),
        .angular_velocity   (angular_velocity),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .x_position         (x_position),
        .y_position         (y_position),
        .heading            (heading),
        .position_saturated (position_saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.match_pose(x_position, y_position, heading, position_saturated);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [VEL_WIDTH-1:0] pick_velocity();
        logic signed [VEL_WIDTH-1:0] r;
        case ($urandom_range(0, 9))
            0: r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: r = VEL_WIDTH'($urandom_range(0, 32) - 16);
            default: r = VEL_WIDTH'($urandom());
        endcase
        return r;
    endfunction

    task automatic send_request(input logic signed [VEL_WIDTH-1:0] v,
                                input logic signed [VEL_WIDTH-1:0] w);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        linear_velocity <= v;
        angular_velocity <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.take_command(v, w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_step(input logic [TIME_WIDTH-1:0] t);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        board.set_step(t);
    endtask

    // Drives straight at full speed until a few clamps are seen or the request cap is reached.
    task automatic drive_until_clamp(input logic signed [VEL_WIDTH-1:0] v, input bit upper);
        int start_hits;
        int n;
        start_hits = upper ? board.clamps_hi : board.clamps_lo;
        n = 0;
        while (((upper ? board.clamps_hi : board.clamps_lo) < start_hits + CLAMP_TARGET)
               && n < DRIVE_CAP)
        begin
            send_request(v, '0);
            n++;
        end
    endtask

    initial
    begin
        int phase;
        int k;
        logic [TIME_WIDTH-1:0] t;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds = 6;
        stall_odds = 6;
        for (k = 0; k < $size(DIR_V); k++)
        begin
            send_request(DIR_V[k], DIR_W[k]);
        end

        // Long straight runs at the largest step carry x far positive and y far negative.
        write_step('1);
        gap_odds = 8;
        stall_odds = 8;
        send_request('0, board.steer_rate('0));
        drive_until_clamp(16'sh7FFF, 1'b1);
        send_request('0, board.steer_rate(QUARTER_TURN));
        drive_until_clamp(16'sh8000, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: t = '0;
                1: t = TIME_WIDTH'(1);
                2: t = '1;
                3: t = 16'h8000;
                5: t = TIME_STEP_RESET;
                default: t = TIME_WIDTH'($urandom_range(2, 65534));
            endcase
            write_step(t);
            if (phase == RANDOM_PHASES - 1)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds = (phase % 3 == 1) ? 0 : $urandom_range(2, 12);
                stall_odds = (phase % 3 == 2) ? 0 : $urandom_range(2, 12);
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                send_request(pick_velocity(), pick_velocity());
                if ($urandom_range(0, 63) == 0)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results for %0d requests across %0d time-step settings,",
                 board.results, board.requests, board.settings);
        $display("with %0d upper and %0d lower position clamps along the way.",
                 board.clamps_hi, board.clamps_lo);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
